/* src/lpht_pkg.sv */
// Shared types and constants for the linear-probing hash table.
// Used by lpht_dp, lpht_ctrl and the top level; no dependencies of its own.
package lpht_pkg;

  localparam int TABLE_SIZE_DEF = 11;
  localparam int KEY_W          = 31;
  localparam int SLOT_W         = 10;
  localparam int PROBES_W       = 11;

  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [PROBES_W-1:0] probes;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic start;
    logic probe;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;
    logic clr_last;
  } sts_t;

endpackage

/* src/lpht_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/lpht_dp.sv */
// Datapath: home-slot reduction, probe walk over the slot RAM, result register.
// Depends on lpht_pkg and lpht_ram.
module lpht_dp #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lpht_pkg::in_item_t in_data,
  input  lpht_pkg::cmd_t     cmd,
  output lpht_pkg::sts_t     sts,
  output lpht_pkg::out_item_t out_data
);
  import lpht_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int OFF_W  = $clog2(TABLE_SIZE + 2);
  localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
  localparam int SHIFT  = KEY_W + IDX_W;
  localparam int MULK_W = KEY_W + 1;
  localparam int PROD_W = KEY_W + MULK_W;
  localparam int REM_W  = IDX_W + 1;
  localparam int RAM_W  = KEY_W + 1;

  // floor(2^SHIFT / TABLE_SIZE): quotient estimate is low by at most one
  localparam logic [63:0]        MUL_K64  = (64'd1 << SHIFT) / TABLE_SIZE;
  localparam logic [MULK_W-1:0]  MUL_K    = MULK_W'(MUL_K64);
  localparam logic [KEY_W-1:0]   TS_KEY   = KEY_W'(TABLE_SIZE);
  localparam logic [REM_W-1:0]   TS_REM   = REM_W'(TABLE_SIZE);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(TABLE_SIZE - 1);
  localparam logic [OFF_W-1:0]   LAST_OFF = OFF_W'(TABLE_SIZE);
  localparam logic [CNT_W-1:0]   FULL_CNT = CNT_W'(TABLE_SIZE);

  // item and modulo pipeline
  logic              func_r;
  logic [KEY_W-1:0]  key_r;
  logic [PROD_W-1:0] prod1_r;
  logic [KEY_W-1:0]  prod2_r, prod2_nxt, quo;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [IDX_W-1:0]  home;

  // walk
  logic [IDX_W-1:0]  p_r, p_next;
  logic [OFF_W-1:0]  c_r;
  logic              res_hit_r, res_empty_r;
  logic [IDX_W-1:0]  res_slot_r;
  logic [OFF_W-1:0]  res_probes_r;
  out_item_t         out_data_r, out_nxt;

  // persistent control
  logic [CNT_W-1:0]  occ_r;
  logic [IDX_W-1:0]  clr_addr_r;

  // RAM
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;

  logic ent_valid, hit, empty, exhausted, done, do_insert;

  assign quo       = KEY_W'(prod1_r >> SHIFT);
  assign prod2_nxt = quo * TS_KEY;
  assign rem_nxt   = REM_W'(key_r - prod2_r);
  assign home      = IDX_W'((rem_r >= TS_REM) ? (rem_r - TS_REM) : rem_r);

  assign p_next    = (p_r == LAST_IDX) ? '0 : p_r + IDX_W'(1);

  assign ent_valid = ram_rdata[KEY_W];
  assign hit       = ent_valid && (ram_rdata[KEY_W-1:0] == key_r);
  assign empty     = !ent_valid;
  assign exhausted = !hit && !empty && (c_r == LAST_OFF);
  assign done      = hit || empty || exhausted;

  assign do_insert = (func_r == FN_INSERT) && !res_hit_r && res_empty_r && (occ_r < FULL_CNT);

  always_comb begin
    out_nxt.slot   = SLOT_W'(res_slot_r);
    out_nxt.probes = PROBES_W'(res_probes_r);
    if (func_r == FN_SEARCH) begin
      out_nxt.status = res_hit_r ? ST_FOUND : ST_NOT_FOUND;
    end else if (res_hit_r) begin
      out_nxt.status = ST_DUPLICATE;
    end else if (do_insert) begin
      out_nxt.status = ST_INSERTED;
    end else begin
      out_nxt.status = ST_FULL;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = '0;
    if (cmd.clear) begin
      ram_we = 1'b1;
    end else if (cmd.finish && do_insert) begin
      ram_we    = 1'b1;
      ram_waddr = res_slot_r;
      ram_wdata = {1'b1, key_r};
    end
  end

  // start reads the home slot; each probe cycle reads ahead to the next one
  assign ram_raddr = cmd.start ? home : p_next;

  lpht_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_SIZE)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_data.func;
      key_r  <= in_data.key;
    end
    prod1_r <= PROD_W'(key_r) * PROD_W'(MUL_K);
    prod2_r <= prod2_nxt;
    rem_r   <= rem_nxt;
    if (cmd.start) begin
      p_r <= home;
      c_r <= '0;
    end else if (cmd.probe) begin
      if (done) begin
        res_hit_r    <= hit;
        res_empty_r  <= empty;
        res_slot_r   <= exhausted ? p_next : p_r;
        res_probes_r <= exhausted ? c_r + OFF_W'(1) : c_r;
      end else begin
        p_r <= p_next;
        c_r <= c_r + OFF_W'(1);
      end
    end
    if (cmd.finish) begin
      out_data_r <= out_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + IDX_W'(1);
      end
      if (cmd.finish && do_insert) begin
        occ_r <= occ_r + CNT_W'(1);
      end
    end
  end

  assign sts.walk_done = done;
  assign sts.clr_last  = (clr_addr_r == LAST_IDX);
  assign out_data      = out_data_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_CNT)
    else $error("occupancy count above table size");

  a_probe_budget: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |-> c_r <= LAST_OFF)
    else $error("probe offset past budget");

  a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && do_insert) |-> (res_probes_r <= LAST_OFF))
    else $error("insert after exhausted walk");

endmodule

/* src/lpht_ctrl.sv */
// Controller FSM: clear sweep, item sequencing, output register handshake.
// Depends on lpht_pkg.
module lpht_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  lpht_pkg::sts_t sts,
  output lpht_pkg::cmd_t cmd
);
  import lpht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_QUO,
    S_REM,
    S_START,
    S_PROBE,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd.capture = in_valid && !in_stall_r;
    cmd.clear   = (state_r == S_CLEAR);
    cmd.start   = (state_r == S_START);
    cmd.probe   = (state_r == S_PROBE);
    cmd.finish  = (state_r == S_FINISH) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:   if (cmd.capture) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_QUO;
      S_QUO:    state_nxt = S_REM;
      S_REM:    state_nxt = S_START;
      S_START:  state_nxt = S_PROBE;
      S_PROBE:  if (sts.walk_done) state_nxt = S_FINISH;
      S_FINISH: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  assign out_valid_nxt = cmd.finish || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      in_stall_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= (state_nxt != S_IDLE);
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (state_r == S_IDLE))
    else $error("item accepted outside idle");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> out_free)
    else $error("result overwrote pending output");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("output valid without finished walk");

endmodule

/* src/linear_probe_hash_table.sv */
// Top level of the linear-probing hash table: controller plus datapath.
// Depends on lpht_pkg, lpht_ctrl, lpht_dp (which holds lpht_ram).
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data    | item {func, key}
//   result  | out_valid, out_stall, out_data | item {status, slot, probes}
//
// Sequence: an accepted item passes the reciprocal-multiply modulo that gives
//   its home slot, then P slot reads on the probe path (1 to TABLE_SIZE+1);
//   the single read port of the slot RAM gives one probe per cycle. No new
//   item is accepted until the previous one has left its final state.
// Reset: a clearing pass writes every slot empty; in_stall stays high until
//   it ends.
// Stalls: a held result sits in the output register while the next item is
//   accepted and walked; that item waits in its final state only if the
//   previous result has still not been taken.
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpht_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpht_pkg::out_item_t out_data
);
  import lpht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing: clear sweep, modulo steps, walk, result handoff
  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slot memory, probe walk, occupancy count, result register
  lpht_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

/* dv/lpht_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for linear_probe_hash_table: watches both channels, keeps its own
// copy of the slot table, predicts each result and compares it when it arrives.
// Depends on lpht_pkg only.
module lpht_checker #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  lpht_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  lpht_pkg::out_item_t out_data,
  output int                  mismatches,
  output int                  awaiting
);
  import lpht_pkg::*;

  logic [KEY_W-1:0] shadow_key  [TABLE_SIZE];
  bit               shadow_used [TABLE_SIZE];
  int unsigned      shadow_count;
  out_item_t        expected_answers [$];
  int               bad_results;

  // Walk the probe path on the shadow table, apply an insert, return the answer.
  function automatic out_item_t lookup_and_update(in_item_t item);
    out_item_t   ans;
    int unsigned home, ofs, pos;
    bit          stop, hit;
    home = item.key % TABLE_SIZE;
    ofs  = 0;
    pos  = home;
    stop = 1'b0;
    hit  = 1'b0;
    while (!stop && ofs <= TABLE_SIZE) begin
      pos = (home + ofs) % TABLE_SIZE;
      if (!shadow_used[pos]) begin
        stop = 1'b1;
      end else if (shadow_key[pos] == item.key) begin
        stop = 1'b1;
        hit  = 1'b1;
      end else begin
        ofs++;
      end
    end
    // budget spent: offset is TABLE_SIZE + 1
    if (!stop) pos = (home + ofs) % TABLE_SIZE;

    if (item.func == FN_SEARCH) begin
      ans.status = hit ? ST_FOUND : ST_NOT_FOUND;
    end else if (hit) begin
      ans.status = ST_DUPLICATE;
    end else if (shadow_count < TABLE_SIZE && !shadow_used[pos]) begin
      shadow_key[pos]  = item.key;
      shadow_used[pos] = 1'b1;
      shadow_count++;
      ans.status = ST_INSERTED;
    end else begin
      ans.status = ST_FULL;
    end
    ans.slot   = SLOT_W'(pos);
    ans.probes = PROBES_W'(ofs);
    return ans;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        shadow_key[i]  = '0;
        shadow_used[i] = 1'b0;
      end
      shadow_count = 0;
      bad_results  = 0;
      expected_answers.delete();
    end else begin
      if (in_valid && !in_stall) expected_answers.push_back(lookup_and_update(in_data));
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("[%0t] unexpected result: status %0d slot %0d probes %0d",
                     $realtime, out_data.status, out_data.slot, out_data.probes);
        end else begin
          want = expected_answers.pop_front();
          if (out_data.status !== want.status || out_data.slot !== want.slot ||
              out_data.probes !== want.probes) begin
            bad_results++;
            if (bad_results <= 10)
              $display("[%0t] mismatch: expected status %0d slot %0d probes %0d, got %0d %0d %0d",
                       $realtime, want.status, want.slot, want.probes,
                       out_data.status, out_data.slot, out_data.probes);
          end
        end
      end
    end
    mismatches <= bad_results;
    awaiting   <= expected_answers.size();
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Top of the hash-table testbench: clock, reset, item stimulus and verdict.
// Depends on lpht_pkg, linear_probe_hash_table and lpht_checker.
module testbench;
  import lpht_pkg::*;

  localparam int TS         = TABLE_SIZE_DEF;
  localparam int N_RANDOM   = 850;
  localparam int LIMIT      = 400_000;   // watchdog limit, in cycles
  localparam int DRAIN_WAIT = 40;        // idle wait after the final drain, in cycles

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int mismatches;
  int awaiting;
  int cycle_count = 0;
  int idle_pct    = 0;   // sender gap chance, read by the stimulus process
  int stall_pct   = 0;   // receiver stall chance, changed by NBA only

  // keys sent as inserts; drawn from to get hits, duplicates and collisions
  logic [KEY_W-1:0] sent_keys [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  linear_probe_hash_table #(.TABLE_SIZE(TS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  lpht_checker #(.TABLE_SIZE(TS)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  // Receiver back-pressure: fresh coin per cycle at the current stall rate.
  always @(posedge clk) begin
    out_stall <= rst_n && stall_pct != 0 && $urandom_range(0, 99) < stall_pct;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one item and hold it until accepted. Called right after a rising edge.
  // Valid is only dropped for an idle gap, so back-to-back items keep it high.
  task automatic push_item(input logic fn, input logic [KEY_W-1:0] key);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid     <= 1'b1;
    in_data.func <= fn;
    in_data.key  <= key;
    if (fn == FN_INSERT) sent_keys.push_back(key);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sender holds off until the block has handed back every pending result.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    logic [31:0] r;
    r = $urandom;
    return r[KEY_W-1:0];
  endfunction

  initial begin
    logic             fn;
    logic [KEY_W-1:0] key;
    int unsigned      pick;
    longint unsigned  wide;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // the clearing pass after reset shows up as in_stall; push_item waits it out

    // ---- directed: empty table, duplicates, collisions, wrap-around ----
    push_item(FN_SEARCH, 0);                 // miss on empty table, home slot 0
    push_item(FN_INSERT, 0);                 // smallest key
    push_item(FN_INSERT, 0);                 // duplicate refused
    push_item(FN_SEARCH, 0);                 // hit at offset 0
    push_item(FN_INSERT, 11);                // same home as 0, lands one step on
    push_item(FN_INSERT, {KEY_W{1'b1}});     // largest key, home 1, lands in slot 2
    push_item(FN_INSERT, 10);                // last slot
    push_item(FN_INSERT, 21);                // home 10, wraps past 0..2 into slot 3
    push_item(FN_SEARCH, 32);                // home 10, miss after the wrap
    push_item(FN_SEARCH, {KEY_W{1'b1}});     // hit off the home slot
    push_item(FN_INSERT, {KEY_W{1'b1}});     // duplicate off the home slot
    push_item(FN_SEARCH, 22);                // home 0, walks the cluster to a miss
    drain_results();

    // ---- random phases: none / sender idle / receiver stall / both ----
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 86; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 86; end
        default: begin idle_pct = 37; stall_pct <= 37; end
      endcase
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        fn   = ($urandom_range(0, 99) < 60) ? FN_SEARCH : FN_INSERT;
        pick = $urandom_range(0, 99);
        if (pick < 45 && sent_keys.size() != 0) begin
          // known key: search hit or duplicate insert
          key = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
        end else begin
          if (pick < 75 && sent_keys.size() != 0) begin
            // fresh key sharing a home slot with a known one: long probe walks
            wide = sent_keys[$urandom_range(0, sent_keys.size() - 1)] % TS;
            wide = wide + 64'(TS) * $urandom_range(0, 195225785);
            key  = wide[KEY_W-1:0];
          end else begin
            key = rand_key();
          end
          // fresh inserts are rare so the table fills slowly over the run
          if (fn == FN_INSERT && $urandom_range(0, 99) >= 4) fn = FN_SEARCH;
        end
        push_item(fn, key);
      end
      drain_results();
    end

    // ---- directed: fill the table, then full-table cases ----
    for (int n = 0; n < TS + 3; n++) push_item(FN_INSERT, rand_key());
    push_item(FN_INSERT, rand_key());        // refused, table full
    push_item(FN_SEARCH, rand_key());        // miss with the whole budget spent
    push_item(FN_SEARCH, 0);                 // hit on a full table
    push_item(FN_INSERT, 11);                // duplicate on a full table

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);      // catch any stray late result
    if (mismatches == 0 && awaiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
